FILE: rtl/eqso_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqso_pkg
// Shared types and constants for the single-outstanding event queue.
// ----------------------------------------------------------------------------
package eqso_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int ACTION_W  = 1;
  localparam int SYMBOL_W  = 16;
  localparam int PAYLOAD_W = 32;
  localparam int EVENT_W   = SYMBOL_W + PAYLOAD_W;
  localparam int COUNT_W   = 5;
  localparam int LIMIT_W   = 5;
  localparam int DEST_W    = 9;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 9;

  localparam logic [LIMIT_W-1:0]       LIMIT_RST = 5'd16;
  localparam logic signed [DEST_W-1:0] CONN_RST  = -9'sd1;

  // input action codes
  localparam logic [ACTION_W-1:0] ACT_POST = 1'b0;
  localparam logic [ACTION_W-1:0] ACT_ACK  = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONNECTION_ID = 1'b1;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming request
    logic execute;  // apply the latched request, load result registers
  } eqso_cmd_t;

endpackage

FILE: rtl/event_queue_single_outstanding_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// event_queue_single_outstanding_core
// Event queue, one event in flight: posts go out at once, wait in a bounded
// FIFO or drop at its limit; a matching ack releases the next waiting event.
// ----------------------------------------------------------------------------
//
//  channel   handshake              payload
//  -------   --------------------   ---------------------------------------
//  request   start & !busy          in_action, in_event_symbol,
//                                   in_event_payload
//  result    out_valid (1 cycle)    out_send_*, out_dropped, out_ack_matched,
//                                   out_queue_length/full, out_nothing_pending
//  config    cfg_valid & cfg_ready  cfg_index, cfg_wdata
//
// Each request is latched at the accept edge, which also reads the FIFO
// head; the execute cycle then updates the queue. The registered read port
// of the wait store is why execute follows the accept edge.
// The result strobes the cycle after execute; a new request may be accepted
// in that same cycle.
// Reset (rst_n low, synchronous) empties the queue, clears pending, and sets
// queue_limit to 16 and connection_id to -1. cfg_ready is always high.
// The receiver cannot stall; every request yields exactly one result.
//
module event_queue_single_outstanding_core import eqso_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // request channel
  input  logic                     start,
  output logic                     busy,
  input  logic [ACTION_W-1:0]      in_action,
  input  logic [SYMBOL_W-1:0]      in_event_symbol,
  input  logic [PAYLOAD_W-1:0]     in_event_payload,
  // config channel
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_wdata,
  // result channel
  output logic                     out_valid,
  output logic                     out_send_valid,
  output logic [SYMBOL_W-1:0]      out_send_symbol,
  output logic [PAYLOAD_W-1:0]     out_send_payload,
  output logic signed [DEST_W-1:0] out_send_destination,
  output logic                     out_dropped,
  output logic                     out_ack_matched,
  output logic [COUNT_W-1:0]       out_queue_length,
  output logic                     out_queue_full,
  output logic                     out_nothing_pending
);

  eqso_cmd_t cmd;

  // config registers sit in the datapath and take a write at any time
  assign cfg_ready = 1'b1;

  eqso_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  eqso_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_wdata            (cfg_wdata),
    .in_action            (in_action),
    .in_event_symbol      (in_event_symbol),
    .in_event_payload     (in_event_payload),
    .out_valid            (out_valid),
    .out_send_valid       (out_send_valid),
    .out_send_symbol      (out_send_symbol),
    .out_send_payload     (out_send_payload),
    .out_send_destination (out_send_destination),
    .out_dropped          (out_dropped),
    .out_ack_matched      (out_ack_matched),
    .out_queue_length     (out_queue_length),
    .out_queue_full       (out_queue_full),
    .out_nothing_pending  (out_nothing_pending)
  );

`ifndef SYNTH
  // an accepted request enters the execute state
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not enter execute");

  // every execute cycle produces a result strobe on the next cycle
  a_busy_result: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (out_valid && !busy))
    else $error("execute cycle not followed by a result");

  // a result never shows while a request is still executing
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe during execute");

  // a request cannot both send and be dropped
  a_send_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_send_valid && out_dropped))
    else $error("request both sent and dropped");
`endif

endmodule

FILE: rtl/eqso_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqso_ctrl
// Sequencer: accepts a request, runs the execute state, then returns idle.
// ----------------------------------------------------------------------------
module eqso_ctrl import eqso_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output eqso_cmd_t cmd
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy        = (state_r != ST_IDLE);
  assign cmd.capture = start && (state_r == ST_IDLE);
  assign cmd.execute = (state_r == ST_EXEC);

endmodule

FILE: rtl/eqso_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqso_datapath
// Wait FIFO, pending-event tracking, config registers and result registers.
// ----------------------------------------------------------------------------
module eqso_datapath import eqso_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  eqso_cmd_t                    cmd,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic [ACTION_W-1:0]          in_action,
  input  logic [SYMBOL_W-1:0]          in_event_symbol,
  input  logic [PAYLOAD_W-1:0]         in_event_payload,
  output logic                         out_valid,
  output logic                         out_send_valid,
  output logic [SYMBOL_W-1:0]          out_send_symbol,
  output logic [PAYLOAD_W-1:0]         out_send_payload,
  output logic signed [DEST_W-1:0]     out_send_destination,
  output logic                         out_dropped,
  output logic                         out_ack_matched,
  output logic [COUNT_W-1:0]           out_queue_length,
  output logic                         out_queue_full,
  output logic                         out_nothing_pending
);

  localparam int PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int DEPTH_CAP = (QUEUE_DEPTH > 31) ? 31 : QUEUE_DEPTH;
  localparam logic [LIMIT_W-1:0] DEPTH_CAP_L = LIMIT_W'(DEPTH_CAP);
  localparam logic [PTR_W-1:0]   PTR_LAST    = PTR_W'(QUEUE_DEPTH - 1);

  // config
  logic [LIMIT_W-1:0]       limit_r;
  logic signed [DEST_W-1:0] conn_r;

  // latched request
  logic [ACTION_W-1:0]  act_r;
  logic [SYMBOL_W-1:0]  sym_r;
  logic [PAYLOAD_W-1:0] pay_r;

  // queue state
  logic [EVENT_W-1:0] mem [QUEUE_DEPTH];
  logic [EVENT_W-1:0] rd_data_r;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic               pend_r, pend_nxt;
  logic [SYMBOL_W-1:0] pend_sym_r, pend_sym_nxt;

  // step decode
  logic [LIMIT_W-1:0]   lim_eff;
  logic                 do_write;
  logic                 send;
  logic                 dropped;
  logic                 matched;
  logic [SYMBOL_W-1:0]  snd_sym;
  logic [PAYLOAD_W-1:0] snd_pay;

  // result registers
  logic                     out_valid_r;
  logic                     send_r;
  logic [SYMBOL_W-1:0]      snd_sym_r;
  logic [PAYLOAD_W-1:0]     snd_pay_r;
  logic signed [DEST_W-1:0] snd_dest_r;
  logic                     dropped_r;
  logic                     matched_r;
  logic [COUNT_W-1:0]       len_r;
  logic                     full_r;
  logic                     nopend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
      conn_r  <= CONN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_QUEUE_LIMIT:   limit_r <= cfg_wdata[LIMIT_W-1:0];
        CFG_CONNECTION_ID: conn_r  <= $signed(cfg_wdata[DEST_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action;
      sym_r <= in_event_symbol;
      pay_r <= in_event_payload;
    end
  end

  assign lim_eff = (limit_r > DEPTH_CAP_L) ? DEPTH_CAP_L : limit_r;

  always_comb begin
    do_write     = 1'b0;
    send         = 1'b0;
    dropped      = 1'b0;
    matched      = 1'b0;
    snd_sym      = '0;
    snd_pay      = '0;
    rd_ptr_nxt   = rd_ptr_r;
    wr_ptr_nxt   = wr_ptr_r;
    cnt_nxt      = cnt_r;
    pend_nxt     = pend_r;
    pend_sym_nxt = pend_sym_r;
    case (act_r)
      ACT_POST: begin
        if (cnt_r >= lim_eff) begin
          dropped = 1'b1;
        end else if (pend_r) begin
          do_write   = 1'b1;
          wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
          cnt_nxt    = cnt_r + COUNT_W'(1);
        end else begin
          send         = 1'b1;
          snd_sym      = sym_r;
          snd_pay      = pay_r;
          pend_nxt     = 1'b1;
          pend_sym_nxt = sym_r;
        end
      end
      ACT_ACK: begin
        if (pend_r && (pend_sym_r == sym_r)) begin
          matched = 1'b1;
          if (cnt_r == '0) begin
            pend_nxt = 1'b0;
          end else begin
            send         = 1'b1;
            snd_sym      = rd_data_r[EVENT_W-1:PAYLOAD_W];
            snd_pay      = rd_data_r[PAYLOAD_W-1:0];
            pend_sym_nxt = rd_data_r[EVENT_W-1:PAYLOAD_W];
            rd_ptr_nxt   = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
            cnt_nxt      = cnt_r - COUNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // wait store: one write port, one registered read port at the head
  always_ff @(posedge clk) begin
    if (cmd.execute && do_write) begin
      mem[wr_ptr_r] <= {sym_r, pay_r};
    end
    rd_data_r <= mem[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.execute;
      if (cmd.execute) begin
        rd_ptr_r <= rd_ptr_nxt;
        wr_ptr_r <= wr_ptr_nxt;
        cnt_r    <= cnt_nxt;
        pend_r   <= pend_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      pend_sym_r <= pend_sym_nxt;
      send_r     <= send;
      snd_sym_r  <= snd_sym;
      snd_pay_r  <= snd_pay;
      snd_dest_r <= send ? conn_r : '0;
      dropped_r  <= dropped;
      matched_r  <= matched;
      len_r      <= cnt_nxt;
      full_r     <= (cnt_nxt >= limit_r);
      nopend_r   <= !pend_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_send_valid       = send_r;
  assign out_send_symbol      = snd_sym_r;
  assign out_send_payload     = snd_pay_r;
  assign out_send_destination = snd_dest_r;
  assign out_dropped          = dropped_r;
  assign out_ack_matched      = matched_r;
  assign out_queue_length     = len_r;
  assign out_queue_full       = full_r;
  assign out_nothing_pending  = nopend_r;

endmodule
